FILE: hdl/csd_pkg.sv
// csd_pkg: types and constants shared by the chip select address decoder
// target and error codes, register indexes, reset values and decode windows
// no dependencies
`default_nettype none

package csd_pkg;

    localparam int unsigned ADDR_W = 24;

    localparam logic [2:0] TGT_CFG    = 3'd0;
    localparam logic [2:0] TGT_PERIPH = 3'd1;
    localparam logic [2:0] TGT_CS0    = 3'd2;
    localparam logic [2:0] TGT_CS3    = 3'd5;
    localparam logic [2:0] TGT_ROM    = 3'd6;
    localparam logic [2:0] TGT_NONE   = 3'd7;

    localparam logic [1:0] ERR_OK            = 2'd0;
    localparam logic [1:0] ERR_UNDECODED     = 2'd1;
    localparam logic [1:0] ERR_BOUNDS        = 2'd2;
    localparam logic [1:0] ERR_PROGRAM_WRITE = 2'd3;

    localparam logic [2:0] CFG_PERIPH_BASE = 3'd0;
    localparam logic [2:0] CFG_SELECT0     = 3'd1;
    localparam logic [2:0] CFG_SELECT1     = 3'd2;
    localparam logic [2:0] CFG_SELECT2     = 3'd3;
    localparam logic [2:0] CFG_SELECT3     = 3'd4;

    localparam logic [11:0] PERIPH_BASE_RESET = 12'hfff;
    localparam logic [31:0] SELECT0_RESET     = 32'hc001_dffd;
    localparam logic [31:0] SELECTN_RESET     = 32'hc000_dffd;

    localparam logic [23:0] CFG_WIN_LO  = 24'h0000f0;
    localparam logic [23:0] CFG_WIN_END = 24'h0000ff;
    localparam logic [23:0] PERIPH_OFF_MASK = 24'h000fff;
    localparam logic [15:0] CS_FIELD_MASK = 16'h1ffc;
    localparam logic [15:0] CS_BANK_MASK  = 16'he000;

    typedef struct packed {
        logic        kind;
        logic [23:0] address;
        logic [2:0]  function_code;
    } req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [23:0] offset;
        logic [1:0]  error;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/csd_if.sv
// csd interfaces: request, response and configuration write channels
// valid/ready handshake; no dependencies
`default_nettype none

interface csd_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [23:0] address;
    logic [2:0]  function_code;

    modport source (output valid, kind, address, function_code, input ready);
    modport sink (input valid, kind, address, function_code, output ready);
endinterface

interface csd_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [23:0] offset;
    logic [1:0]  error;

    modport source (output valid, target, offset, error, input ready);
    modport sink (input valid, target, offset, error, output ready);
endinterface

interface csd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/chip_select_address_decoder_unit.sv
// chip_select_address_decoder_unit: decodes one bus request per cycle while the response side keeps up
// uses csd_pkg and the interfaces in csd_if.sv
`default_nettype none

// Each request (kind, address, function code) is decoded in priority order:
// program-space write error, system configuration window 0xF0..0xFE, the 4 KiB
// peripheral block, chip selects 0..3, ROM fallback, else undecoded. A request
// is taken into an input register, decoded by one level of compare logic and
// held in a result register, so the block takes one request per cycle while the
// response side keeps up; a waiting result stops the next request only once the
// input register is full. Configuration writes always complete, as cfg.ready is
// tied high, and must be issued only while the block is idle.
module chip_select_address_decoder_unit #(
    parameter int unsigned ROM_BYTES = 4194304,
    parameter int unsigned RAM_BYTES = 2097152,
    parameter int unsigned CS2_BYTES = 524288,
    parameter int unsigned CS3_BYTES = 262144
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    csd_cfg_if.sink      cfg,
    csd_req_if.sink      req,
    csd_rsp_if.source    rsp
);

    localparam logic [3:0][24:0] CS_SIZE = {
        25'(CS3_BYTES), 25'(CS2_BYTES), 25'(RAM_BYTES), 25'(ROM_BYTES)
    };
    localparam logic [24:0] ROM_LIMIT = 25'(ROM_BYTES);

    logic [11:0]        periph_base_reg;
    logic [3:0][31:0]   select_reg;

    logic               s1_valid_reg;
    csd_pkg::req_t      s1_reg;
    logic               out_valid_reg;
    csd_pkg::rsp_t      out_reg;

    logic               in_ready;
    logic               out_load;
    csd_pkg::rsp_t      out_next;

    logic [3:0]         cs_hit;
    logic [3:0][23:0]   cs_off;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periph_base_reg <= csd_pkg::PERIPH_BASE_RESET;
            select_reg[0]   <= csd_pkg::SELECT0_RESET;
            select_reg[1]   <= csd_pkg::SELECTN_RESET;
            select_reg[2]   <= csd_pkg::SELECTN_RESET;
            select_reg[3]   <= csd_pkg::SELECTN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                csd_pkg::CFG_PERIPH_BASE: periph_base_reg <= cfg.data[11:0];
                csd_pkg::CFG_SELECT0:     select_reg[0]   <= cfg.data;
                csd_pkg::CFG_SELECT1:     select_reg[1]   <= cfg.data;
                csd_pkg::CFG_SELECT2:     select_reg[2]   <= cfg.data;
                csd_pkg::CFG_SELECT3:     select_reg[3]   <= cfg.data;
                default: ;
            endcase
        end
    end

    // handshake
    assign out_load  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign in_ready  = !s1_valid_reg || out_load;
    assign req.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (out_load)
                s1_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && in_ready)
        begin
            s1_reg.kind          <= req.kind;
            s1_reg.address       <= req.address;
            s1_reg.function_code <= req.function_code;
        end
        if (out_load)
            out_reg <= out_next;
    end

    // chip select match
    always_comb
    begin
        logic [15:0] br;
        logic [15:0] opt;
        logic [12:0] base;
        logic [12:0] mask;
        for (int i = 0; i < 4; i++)
        begin
            br   = select_reg[i][31:16];
            opt  = select_reg[i][15:0];
            base = br[12:0] & csd_pkg::CS_FIELD_MASK[12:0];
            mask = opt[12:0] & csd_pkg::CS_FIELD_MASK[12:0];
            cs_hit[i] = br[0]
                && !(opt[0] && ((br & csd_pkg::CS_BANK_MASK) == 16'h0000))
                && ((s1_reg.address[23:11] & mask) == (base & mask));
            cs_off[i] = s1_reg.address & ~{base, 11'd0};
        end
    end

    // priority decode
    always_comb
    begin
        out_next.target = csd_pkg::TGT_NONE;
        out_next.offset = '0;
        out_next.error  = csd_pkg::ERR_UNDECODED;
        if (s1_reg.kind && s1_reg.function_code[1])
        begin
            out_next.error = csd_pkg::ERR_PROGRAM_WRITE;
        end
        else if (s1_reg.address >= csd_pkg::CFG_WIN_LO
                 && s1_reg.address < csd_pkg::CFG_WIN_END)
        begin
            out_next.target = csd_pkg::TGT_CFG;
            out_next.offset = s1_reg.address;
            out_next.error  = csd_pkg::ERR_OK;
        end
        else if (s1_reg.address[23:12] == periph_base_reg)
        begin
            out_next.target = csd_pkg::TGT_PERIPH;
            out_next.offset = s1_reg.address & csd_pkg::PERIPH_OFF_MASK;
            out_next.error  = csd_pkg::ERR_OK;
        end
        else if (cs_hit != 4'b0000)
        begin
            for (int i = 3; i >= 0; i--)
            begin
                if (cs_hit[i])
                begin
                    out_next.target = csd_pkg::TGT_CS0 + 3'(i);
                    out_next.offset = cs_off[i];
                    out_next.error  = ({1'b0, cs_off[i]} >= CS_SIZE[i])
                                      ? csd_pkg::ERR_BOUNDS : csd_pkg::ERR_OK;
                end
            end
        end
        else if ({1'b0, s1_reg.address} < ROM_LIMIT)
        begin
            out_next.target = csd_pkg::TGT_ROM;
            out_next.offset = s1_reg.address;
            out_next.error  = csd_pkg::ERR_OK;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.target = out_reg.target;
    assign rsp.offset = out_reg.offset;
    assign rsp.error  = out_reg.error;

    a_prog_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.error == csd_pkg::ERR_PROGRAM_WRITE
        |-> rsp.target == csd_pkg::TGT_NONE && rsp.offset == 24'd0)
        else $error("program write result not target none");

    a_undecoded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.error == csd_pkg::ERR_UNDECODED
        |-> rsp.target == csd_pkg::TGT_NONE && rsp.offset == 24'd0)
        else $error("undecoded result carries a target");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.error == csd_pkg::ERR_BOUNDS
        |-> rsp.target >= csd_pkg::TGT_CS0 && rsp.target <= csd_pkg::TGT_CS3)
        else $error("bounds error outside chip selects");

    a_periph_off: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.target == csd_pkg::TGT_PERIPH |-> rsp.offset[23:12] == 12'd0)
        else $error("peripheral offset beyond 4 KiB");

endmodule

`default_nettype wire
